>>> sv/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

  localparam int ENTRIES_DEFAULT = 128;
  localparam int MAX_ADDR_W      = 10;
  localparam int IP_W            = 32;
  localparam int MAC_W           = 48;
  localparam int OUTCOME_W       = 2;
  localparam int SLOT_W          = 7;

  localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DROPPED  = 2'd2;

  // write command from the sequencer to the table memories
  typedef struct packed {
    logic                  wr_ip;
    logic                  wr_mac;
    logic [MAX_ADDR_W-1:0] addr;
    logic [IP_W-1:0]       ip;
    logic [MAC_W-1:0]      mac;
  } tbl_cmd_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
  } res_t;

endpackage

`default_nettype wire

>>> sv/arpc_table.sv
`default_nettype none

module arpc_table #(
  parameter int TABLE_ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rd_en,
  input  wire [arpc_pkg::MAX_ADDR_W-1:0]  rd_addr,
  output logic [arpc_pkg::IP_W-1:0]       rd_data,
  input  wire arpc_pkg::tbl_cmd_t         cmd
);
  import arpc_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.wr_ip) begin
      ip_mem[cmd.addr[AW-1:0]] <= cmd.ip;
    end
    if (cmd.wr_mac) begin
      mac_mem[cmd.addr[AW-1:0]] <= cmd.mac;
    end
  end

  // registered read of the address column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ip_mem[rd_addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> sv/arpc_walk.sv
`default_nettype none

module arpc_walk #(
  parameter int TABLE_ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            busy,
  input  wire [arpc_pkg::IP_W-1:0]        ip_address,
  input  wire [arpc_pkg::MAC_W-1:0]       mac_address,
  output logic                            rd_en,
  output logic [arpc_pkg::MAX_ADDR_W-1:0] rd_addr,
  input  wire [arpc_pkg::IP_W-1:0]        rd_data,
  output arpc_pkg::tbl_cmd_t              cmd,
  output logic                            res_valid,
  input  wire                             res_take,
  output arpc_pkg::res_t                  res
);
  import arpc_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    fill;
  logic             pend;
  logic [AW-1:0]    pend_idx;

  logic hit;
  logic room;
  logic decide;

  // valid slots always form the prefix [0, fill)
  assign room   = fill < CW'(TABLE_ENTRIES);
  assign hit    = (state == S_WALK) && pend && (rd_data == ip_q);
  assign rd_en  = (state == S_WALK) && !hit && (idx < fill);
  assign decide = (state == S_WALK) && !hit && !rd_en && !pend;
  assign rd_addr = MAX_ADDR_W'(idx[AW-1:0]);
  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    cmd.wr_ip  = 1'b0;
    cmd.wr_mac = 1'b0;
    cmd.addr   = MAX_ADDR_W'(pend_idx);
    cmd.ip     = ip_q;
    cmd.mac    = mac_q;
    if (hit) begin
      cmd.wr_mac = 1'b1;
    end else if (decide && room) begin
      cmd.wr_ip  = 1'b1;
      cmd.wr_mac = 1'b1;
      cmd.addr   = MAX_ADDR_W'(fill[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_WALK;
            pend  <= 1'b0;
          end
        end
        S_WALK: begin
          if (hit) begin
            pend  <= 1'b0;
            state <= S_DONE;
          end else if (rd_en) begin
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            if (room) begin
              fill <= fill + CW'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload, walk pointers and result, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ip_q  <= ip_address;
        mac_q <= mac_address;
        idx   <= '0;
      end
      S_WALK: begin
        if (hit) begin
          res.outcome <= OUT_UPDATED;
          res.slot    <= SLOT_W'(pend_idx);
        end else if (rd_en) begin
          idx      <= idx + CW'(1);
          pend_idx <= idx[AW-1:0];
        end else if (decide) begin
          if (room) begin
            res.outcome <= OUT_INSERTED;
            res.slot    <= SLOT_W'(fill);
          end else begin
            res.outcome <= OUT_DROPPED;
            res.slot    <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/arp_cache_update_core.sv
`default_nettype none
// The walk compares the input against the filled slots in order, from slot zero;
//   a hit ends it early. The result then passes through the output register.
// A new beat is accepted only while the sequencer is idle, so beats do not overlap;
//   the serial walk over the single read port of the address memory sets the rate.
// Reset: clears the fill count, the sequencer and the output valid flag.
//   Memory contents are left as they are; no clearing pass.

module arp_cache_update_core #(
  parameter int TABLE_ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [arpc_pkg::IP_W-1:0]          ip_address,
  input  wire [arpc_pkg::MAC_W-1:0]         mac_address,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [arpc_pkg::OUTCOME_W-1:0]    outcome,
  output logic [arpc_pkg::SLOT_W-1:0]       slot
);
  import arpc_pkg::*;

  // Table memories: address column read during the walk, MAC column only written.
  logic                  rd_en;
  logic [MAX_ADDR_W-1:0] rd_addr;
  logic [IP_W-1:0]       rd_data;
  tbl_cmd_t              cmd;

  // Sequencer result, handed to the output register
  logic res_valid;
  logic res_take;
  res_t res;

  arpc_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .cmd     (cmd)
  );

  // The walk reads one slot a cycle and compares the previous one, so it is
  // pipelined over the read latency. A hit rewrites the MAC and stops early;
  // otherwise the pair lands at the fill pointer, or is dropped when the table is
  // full; the fill pointer is also the lowest free slot since slots are never released.
  arpc_walk #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .busy        (in_stall),
    .ip_address  (ip_address),
    .mac_address (mac_address),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  // Output register: a new beat may be accepted while this still waits.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      outcome <= res.outcome;
      slot    <= res.slot;
    end
  end

`ifndef SYNTHESIS
  // accepted beat always starts a walk
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer not busy after input beat");

  // dropped beats report slot zero
  a_drop_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_DROPPED) |-> (slot == '0))
    else $error("dropped beat with nonzero slot");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outcome == OUT_UPDATED) || (outcome == OUT_INSERTED) ||
                  (outcome == OUT_DROPPED))
    else $error("illegal outcome code");

  // a result moves into the output register only while the sequencer is busy
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    res_take |-> in_stall)
    else $error("result taken while sequencer idle");
`endif

endmodule

`default_nettype wire
